@@ src/euler_zyx_rotation_matrix_top_assert.svh @@
// Assertion macros used by the block's top-level module.
`ifndef EULER_ZYX_ROTATION_MATRIX_TOP_ASSERT_SVH
`define EULER_ZYX_ROTATION_MATRIX_TOP_ASSERT_SVH

// Checks that an implication holds on every clock edge outside reset.
`define EZR_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Checks that an implication holds in the cycle after its antecedent.
`define EZR_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ezr_pkg.sv @@
package ezr_pkg;
  localparam int WORK_FRAC = 30;
  localparam int IN_WIDTH = 19;
  localparam int OUT_WIDTH = 17;
  localparam int CORDIC_ITERS = 30;
  localparam int DEF_ANGLE_FRAC_BITS = 15;
  localparam int DEF_ENTRY_FRAC_BITS = 15;
  // Working values: Q2.30 angles and trig values fit in 36 signed bits.
  localparam int WW = 36;
  localparam logic signed [WW-1:0] Q30_PI = 36'sd3373259426;
  localparam logic signed [WW-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [WW-1:0] Q30_TWO_PI = 36'sd6746518852;
  localparam logic signed [WW-1:0] CORDIC_GAIN = 36'sd652032874;

  typedef enum logic [1:0] {
    OP_ROT = 2'd0, OP_DA = 2'd1, OP_DB = 2'd2, OP_DG = 2'd3
  } op_t;

  typedef logic signed [WW-1:0] w_t;

  typedef struct packed {
    op_t op;
    logic neg_a, neg_b, neg_g;
    w_t xa, ya, za, xb, yb, zb, xg, yg, zg;
  } cell_t;

  function automatic w_t atan_at(input int i);
    logic [31:0] t [CORDIC_ITERS];
    t = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
          32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
          32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
          32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
          32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
          32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002};
    return w_t'({4'b0, t[i]});
  endfunction

  // Rounded Q2.30 product.
  function automatic w_t qmul(input w_t a, input w_t b);
    logic signed [2*WW-1:0] p;
    p = a * b + (72'sd1 <<< (WORK_FRAC - 1));
    return w_t'(p >>> WORK_FRAC);
  endfunction
endpackage

@@ src/ezr_if.sv @@
interface ezr_in_if;
  logic valid;
  logic ready;
  logic [1:0] operation;
  logic signed [18:0] alpha_angle;
  logic signed [18:0] beta_angle;
  logic signed [18:0] gamma_angle;
  modport source (output valid, operation, alpha_angle, beta_angle, gamma_angle,
                  input ready);
  modport sink (input valid, operation, alpha_angle, beta_angle, gamma_angle,
                output ready);
endinterface

interface ezr_out_if;
  logic valid;
  logic ready;
  logic signed [16:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

@@ src/ezr_reduce.sv @@
module ezr_reduce #(
  parameter int ANGLE_FRAC_BITS = ezr_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  logic clk,
  input  logic en,
  input  logic signed [18:0] angle,
  output ezr_pkg::w_t r,
  output logic neg_cos
);
  import ezr_pkg::*;
  localparam int SW = IN_WIDTH + WORK_FRAC - ANGLE_FRAC_BITS;
  localparam int CW = ((SW > WW) ? SW : WW) + 2;
  // Whole periods on either side of zero that the scaled angle can reach.
  localparam longint NP = (longint'(1) <<< (SW - 1)) / longint'(Q30_TWO_PI) + 1;
  typedef logic signed [CW-1:0] wide_t;
  wide_t scaled, cand;
  w_t m, m_next, rr;
  logic neg;
  // Stage 1: scale to Q2.30 and fold into [0, 2pi). Every whole-period offset is
  // tried side by side and the single candidate that lands in range is kept.
  always_comb begin
    scaled = wide_t'(angle) <<< (WORK_FRAC - ANGLE_FRAC_BITS);
    m_next = '0;
    for (longint k = -NP; k <= NP; k++) begin
      cand = scaled - wide_t'(k) * wide_t'(Q30_TWO_PI);
      if (cand >= 0 && cand < wide_t'(Q30_TWO_PI)) m_next = w_t'(cand);
    end
  end
  always_ff @(posedge clk) begin
    if (en) m <= m_next;
  end
  always_comb begin
    rr = m;
    neg = 1'b0;
    if (rr >= Q30_PI) rr = rr - Q30_TWO_PI;
    if (rr > Q30_HALF_PI) begin
      rr = Q30_PI - rr;
      neg = 1'b1;
    end else if (rr < -Q30_HALF_PI) begin
      rr = -Q30_PI - rr;
      neg = 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      r <= rr;
      neg_cos <= neg;
    end
  end
endmodule

@@ src/ezr_cell.sv @@
module ezr_cell #(
  parameter int STEP = 0
) (
  input  logic clk,
  input  logic en,
  input  ezr_pkg::cell_t d,
  output ezr_pkg::cell_t q
);
  import ezr_pkg::*;
  cell_t n;
  // One CORDIC rotation for each of the three angles.
  always_comb begin
    n = d;
    if (d.za >= 0) begin
      n.xa = d.xa - (d.ya >>> STEP); n.ya = d.ya + (d.xa >>> STEP);
      n.za = d.za - atan_at(STEP);
    end else begin
      n.xa = d.xa + (d.ya >>> STEP); n.ya = d.ya - (d.xa >>> STEP);
      n.za = d.za + atan_at(STEP);
    end
    if (d.zb >= 0) begin
      n.xb = d.xb - (d.yb >>> STEP); n.yb = d.yb + (d.xb >>> STEP);
      n.zb = d.zb - atan_at(STEP);
    end else begin
      n.xb = d.xb + (d.yb >>> STEP); n.yb = d.yb - (d.xb >>> STEP);
      n.zb = d.zb + atan_at(STEP);
    end
    if (d.zg >= 0) begin
      n.xg = d.xg - (d.yg >>> STEP); n.yg = d.yg + (d.xg >>> STEP);
      n.zg = d.zg - atan_at(STEP);
    end else begin
      n.xg = d.xg + (d.yg >>> STEP); n.yg = d.yg - (d.xg >>> STEP);
      n.zg = d.zg + atan_at(STEP);
    end
  end
  always_ff @(posedge clk) begin
    if (en) q <= n;
  end
endmodule

@@ src/ezr_matrix.sv @@
module ezr_matrix #(
  parameter int ENTRY_FRAC_BITS = ezr_pkg::DEF_ENTRY_FRAC_BITS
) (
  input  logic clk,
  input  logic en,
  input  ezr_pkg::cell_t d,
  output logic signed [16:0] m [9]
);
  import ezr_pkg::*;
  localparam int SH = WORK_FRAC - ENTRY_FRAC_BITS;
  localparam logic signed [WW-1:0] LIM = w_t'(1) <<< ENTRY_FRAC_BITS;

  function automatic logic signed [16:0] to_out(input w_t v);
    w_t t;
    t = v;
    if (SH > 0) t = (t + (w_t'(1) <<< (SH - 1))) >>> SH;
    if (t > LIM) t = LIM;
    if (t < -LIM) t = -LIM;
    return t[16:0];
  endfunction

  // Stage A: sines and cosines.
  w_t sa, ca, sb, cb, sg, cg;
  op_t op1, op2, op3;
  always_ff @(posedge clk) begin
    if (en) begin
      sa <= d.ya; ca <= d.neg_a ? -d.xa : d.xa;
      sb <= d.yb; cb <= d.neg_b ? -d.xb : d.xb;
      sg <= d.yg; cg <= d.neg_g ? -d.xg : d.xg;
      op1 <= d.op;
    end
  end
  // Stage B: two-factor products.
  w_t sasb, casb, sacb, cacb, cacg, casg, sacg, sasg, cbcg, cbsg, sbcg, sbsg;
  w_t sb2, cb2, cg2, sg2;
  always_ff @(posedge clk) begin
    if (en) begin
      sasb <= qmul(sa, sb); casb <= qmul(ca, sb);
      sacb <= qmul(sa, cb); cacb <= qmul(ca, cb);
      cacg <= qmul(ca, cg); casg <= qmul(ca, sg);
      sacg <= qmul(sa, cg); sasg <= qmul(sa, sg);
      cbcg <= qmul(cb, cg); cbsg <= qmul(cb, sg);
      sbcg <= qmul(sb, cg); sbsg <= qmul(sb, sg);
      sb2 <= sb; cb2 <= cb; cg2 <= cg; sg2 <= sg;
      op2 <= op1;
    end
  end
  // Stage C: three-factor products.
  w_t p, q, s, t, u0, u1, v0, v1;
  w_t cacg3, casg3, sacg3, sasg3, cbcg3, cbsg3, sbcg3, sbsg3, sb3, cb3, sasb3, casb3;
  w_t sacb3, cacb3;
  always_ff @(posedge clk) begin
    if (en) begin
      p <= qmul(sasb, cg2); q <= qmul(casb, cg2);
      s <= qmul(sasb, sg2); t <= qmul(casb, sg2);
      u0 <= qmul(sacb, cg2); u1 <= qmul(cacb, cg2);
      v0 <= qmul(sacb, sg2); v1 <= qmul(cacb, sg2);
      cacg3 <= cacg; casg3 <= casg; sacg3 <= sacg; sasg3 <= sasg;
      cbcg3 <= cbcg; cbsg3 <= cbsg; sbcg3 <= sbcg; sbsg3 <= sbsg;
      sb3 <= sb2; cb3 <= cb2; sasb3 <= sasb; casb3 <= casb;
      sacb3 <= sacb; cacb3 <= cacb;
      op3 <= op2;
    end
  end
  // Stage D: select, sum, round and saturate.
  w_t e [9];
  always_comb begin
    case (op3)
      OP_ROT: begin
        e = '{cbcg3, p - casg3, q + sasg3, cbsg3, s + cacg3, t - sacg3,
              -sb3, sacb3, cacb3};
      end
      OP_DA: begin
        e = '{w_t'(0), q + sasg3, -p + casg3, w_t'(0), t - sacg3, -s - cacg3,
              w_t'(0), cacb3, -sacb3};
      end
      OP_DB: begin
        e = '{-sbcg3, u0, u1, -sbsg3, v0, v1, -cb3, -sasb3, -casb3};
      end
      default: begin
        e = '{-cbsg3, -s - cacg3, -t + sacg3, cbcg3, p - casg3, q + sasg3,
              w_t'(0), w_t'(0), w_t'(0)};
      end
    endcase
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) m[k] <= to_out(e[k]);
    end
  end
endmodule

@@ src/euler_zyx_rotation_matrix_top.sv @@
// ZYX Euler rotation matrix: each transaction takes an operation code and three
// Q3.15 angles and returns R = Rz(gamma) Ry(beta) Rx(alpha), or its derivative in
// one angle, as nine saturated Q1.15 entries. A new transaction is accepted every
// cycle unless the output stalls. Each one passes through two angle reduction
// stages, a chain of 30 CORDIC cells that rotate all three angles together, and
// four stages that form the products and round the entries.
// The whole pipeline advances when the output register is empty or being read.
`include "euler_zyx_rotation_matrix_top_assert.svh"
module euler_zyx_rotation_matrix_top #(
  parameter int ANGLE_FRAC_BITS = ezr_pkg::DEF_ANGLE_FRAC_BITS,
  parameter int ENTRY_FRAC_BITS = ezr_pkg::DEF_ENTRY_FRAC_BITS
) (
  input logic clk,
  input logic rst,
  ezr_in_if.sink  in_ch,
  ezr_out_if.source out_ch
);
  import ezr_pkg::*;
  localparam int LAT = 2 + CORDIC_ITERS + 4;

  logic en;
  logic [LAT-1:0] vld;
  assign en = !vld[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], in_ch.valid};
  end

  w_t ra, rb, rg;
  logic na, nb, ng;
  op_t op0, op1;
  ezr_reduce #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_ra (
    .clk(clk), .en(en), .angle(in_ch.alpha_angle), .r(ra), .neg_cos(na));
  ezr_reduce #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_rb (
    .clk(clk), .en(en), .angle(in_ch.beta_angle), .r(rb), .neg_cos(nb));
  ezr_reduce #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_rg (
    .clk(clk), .en(en), .angle(in_ch.gamma_angle), .r(rg), .neg_cos(ng));
  always_ff @(posedge clk) begin
    if (en) begin
      op0 <= op_t'(in_ch.operation);
      op1 <= op0;
    end
  end

  cell_t chain [CORDIC_ITERS+1];
  assign chain[0] = '{op: op1, neg_a: na, neg_b: nb, neg_g: ng,
                      xa: CORDIC_GAIN, ya: '0, za: ra,
                      xb: CORDIC_GAIN, yb: '0, zb: rb,
                      xg: CORDIC_GAIN, yg: '0, zg: rg};
  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cell
    ezr_cell #(.STEP(i)) u_cell (.clk(clk), .en(en), .d(chain[i]), .q(chain[i+1]));
  end

  logic signed [16:0] m [9];
  ezr_matrix #(.ENTRY_FRAC_BITS(ENTRY_FRAC_BITS)) u_mat (
    .clk(clk), .en(en), .d(chain[CORDIC_ITERS]), .m(m));

  assign out_ch.valid = vld[LAT-1];
  assign out_ch.m00 = m[0];
  assign out_ch.m01 = m[1];
  assign out_ch.m02 = m[2];
  assign out_ch.m10 = m[3];
  assign out_ch.m11 = m[4];
  assign out_ch.m12 = m[5];
  assign out_ch.m20 = m[6];
  assign out_ch.m21 = m[7];
  assign out_ch.m22 = m[8];

  `EZR_ASSERT_IMP(a_ready_when_empty, clk, rst, !out_ch.valid, in_ch.ready,
                  "not ready while output empty")
  `EZR_ASSERT_NEXT(a_stall_holds, clk, rst, out_ch.valid && !out_ch.ready,
                   out_ch.valid && $stable(vld), "pipeline moved during stall")
  `EZR_ASSERT_NEXT(a_enter, clk, rst, in_ch.valid && in_ch.ready, vld[0],
                   "accepted transaction not tracked")
endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import ezr_pkg::*;

  typedef logic signed [63:0] q_t;

  typedef struct {
    logic signed [16:0] m [9];
  } matrix_t;

  typedef struct {
    q_t s;
    q_t c;
  } trig_t;

  localparam int LATENCY = 36;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  longint cycle_count = 0;
  bit idle_free = 1'b0;

  ezr_in_if in_ch ();
  ezr_out_if out_ch ();

  euler_zyx_rotation_matrix_top dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #6 clk = ~clk;

  function automatic q_t floor_shift(input q_t v, input int s);
    return v >>> s;
  endfunction

  function automatic trig_t angle_trig(input logic signed [18:0] ang);
    trig_t res;
    q_t r, x, y, dx, dy;
    bit flip;
    q_t atan_q [30];
    atan_q = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
               64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
               64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
               64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
               64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
               64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};
    r = q_t'(ang) * 64'sd32768;
    flip = 1'b0;
    r = r % 64'sd6746518852;
    if (r < 0) r = r + 64'sd6746518852;
    if (r >= 64'sd3373259426) r = r - 64'sd6746518852;
    if (r > 64'sd1686629713) begin
      r = 64'sd3373259426 - r;
      flip = 1'b1;
    end else if (r < -64'sd1686629713) begin
      r = -64'sd3373259426 - r;
      flip = 1'b1;
    end
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (r >= 0) begin
        x = x - dx;
        y = y + dy;
        r = r - atan_q[i];
      end else begin
        x = x + dx;
        y = y - dy;
        r = r + atan_q[i];
      end
    end
    res.s = y;
    res.c = flip ? -x : x;
    return res;
  endfunction

  function automatic q_t qprod(input q_t a, input q_t b);
    return floor_shift(a * b + 64'sd536870912, 30);
  endfunction

  function automatic logic signed [16:0] to_entry(input q_t v);
    q_t t;
    t = floor_shift(v + 64'sd16384, 15);
    if (t > 32768) t = 32768;
    if (t < -32768) t = -32768;
    return t[16:0];
  endfunction

  function automatic matrix_t rotation_entries(input op_t op, input logic signed [18:0] al,
                                               input logic signed [18:0] be,
                                               input logic signed [18:0] ga);
    matrix_t res;
    trig_t a, b, g;
    q_t e [9];
    q_t sasb, casb, sacb, cacb, p, q, s, t, cacg, casg, sacg, sasg, cbcg, cbsg;
    a = angle_trig(al);
    b = angle_trig(be);
    g = angle_trig(ga);
    sasb = qprod(a.s, b.s);
    casb = qprod(a.c, b.s);
    sacb = qprod(a.s, b.c);
    cacb = qprod(a.c, b.c);
    p = qprod(sasb, g.c);
    q = qprod(casb, g.c);
    s = qprod(sasb, g.s);
    t = qprod(casb, g.s);
    cacg = qprod(a.c, g.c);
    casg = qprod(a.c, g.s);
    sacg = qprod(a.s, g.c);
    sasg = qprod(a.s, g.s);
    cbcg = qprod(b.c, g.c);
    cbsg = qprod(b.c, g.s);
    case (op)
      OP_ROT: e = '{cbcg, p - casg, q + sasg, cbsg, s + cacg, t - sacg, -b.s, sacb, cacb};
      OP_DA: e = '{0, q + sasg, -p + casg, 0, t - sacg, -s - cacg, 0, cacb, -sacb};
      OP_DB: e = '{-qprod(b.s, g.c), qprod(sacb, g.c), qprod(cacb, g.c),
                   -qprod(b.s, g.s), qprod(sacb, g.s), qprod(cacb, g.s),
                   -b.c, -sasb, -casb};
      default: e = '{-cbsg, -s - cacg, -t + sacg, cbcg, p - casg, q + sasg, 0, 0, 0};
    endcase
    for (int k = 0; k < 9; k++) res.m[k] = to_entry(e[k]);
    return res;
  endfunction

  class matrix_scoreboard;
    matrix_t pending [$];
    int mismatches = 0;

    function void note_input(op_t op, logic signed [18:0] al, logic signed [18:0] be,
                             logic signed [18:0] ga);
      pending.push_back(rotation_entries(op, al, be, ga));
    endfunction

    function void check_result(matrix_t got);
      matrix_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction");
        return;
      end
      want = pending.pop_front();
      for (int k = 0; k < 9; k++) begin
        if (got.m[k] !== want.m[k]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Entry m%0d%0d mismatch: expected %0d, actual %0d",
                     k / 3, k % 3, want.m[k], got.m[k]);
        end
      end
    endfunction
  endclass

  matrix_scoreboard board = new();

  task automatic send_angles(input op_t op, input logic signed [18:0] al,
                             input logic signed [18:0] be, input logic signed [18:0] ga);
    int gap;
    if (!idle_free && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.alpha_angle <= al;
    in_ch.beta_angle <= be;
    in_ch.gamma_angle <= ga;
    do @(posedge clk); while (!in_ch.ready);
    board.note_input(op, al, be, ga);
    @(negedge clk);
  endtask

  function automatic logic signed [18:0] random_angle();
    case ($urandom_range(0, 5))
      0: return 19'sh3FFFF;
      1: return -19'sh40000;
      2: return 19'($urandom_range(0, 200)) - 19'sd100;
      default: return 19'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [18:0] corner [6];
    corner = '{19'sd0, 19'sh3FFFF, -19'sh40000, 19'sd51472, -19'sd51472, 19'sd102944};
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.alpha_angle = '0;
    in_ch.beta_angle = '0;
    in_ch.gamma_angle = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int k = 0; k < 24; k++)
      send_angles(op_t'(k % 4), corner[k % 6], corner[(k / 4) % 6], corner[(k + 3) % 6]);
    for (int n = 0; n < 1650; n++) begin
      if (n == 1400) idle_free = 1'b1;
      send_angles(op_t'($urandom_range(0, 3)), random_angle(), random_angle(),
                  random_angle());
    end
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (board.mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // The sink stalls in random bursts until the final stretch of the run.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (1) begin
      if (!idle_free && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 14);
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    matrix_t got;
    cycle_count <= cycle_count + 1;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.m = '{out_ch.m00, out_ch.m01, out_ch.m02, out_ch.m10, out_ch.m11, out_ch.m12,
                out_ch.m20, out_ch.m21, out_ch.m22};
      board.check_result(got);
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end
endmodule

@@ euler_zyx_rotation_matrix_top.f @@
+incdir+src
src/ezr_pkg.sv
src/ezr_if.sv
src/ezr_reduce.sv
src/ezr_cell.sv
src/ezr_matrix.sv
src/euler_zyx_rotation_matrix_top.sv
bench/tb_top.sv
